FILE: src/pbrd_pkg.sv
// ----------------------------------------------------------------------------
// pbrd_pkg
// Shared types and constants for the PackBits row decoder.
// ----------------------------------------------------------------------------
package pbrd_pkg;

    localparam int unsigned MAX_ROW_BYTES_DEF = 32767;
    localparam int unsigned ROW_LEN_W         = 15;
    localparam logic [ROW_LEN_W-1:0] ROW_LENGTH_RESET = 15'd1;

    // row_status codes
    localparam logic [1:0] ROW_CONTINUES = 2'd0;
    localparam logic [1:0] ROW_OK        = 2'd1;
    localparam logic [1:0] ROW_FAILED    = 2'd2;

    // PackBits control byte that is skipped
    localparam logic [7:0] CTRL_NOP = 8'h80;

    typedef enum logic [1:0] {
        PH_CONTROL = 2'd0,
        PH_LITERAL = 2'd1,
        PH_REPEAT  = 2'd2,
        PH_FAILED  = 2'd3
    } phase_t;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] in_byte;
        logic       row_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte_first;
        logic [7:0] out_byte_second;
        logic [1:0] byte_count;
        logic [1:0] row_status;
        logic       last;
    } out_item_t;

    // Work handed from the decoder to the emitter: one byte value repeated
    // byte_total times (0..128), plus the row verdict for the final result.
    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] byte_total;
        logic [1:0] status;
    } job_t;

endpackage

FILE: src/packbits_row_decoder_core.sv
// ----------------------------------------------------------------------------
// packbits_row_decoder_core
// PackBits row decoder: one compressed byte in, up to two decoded bytes per result.
// ----------------------------------------------------------------------------
// Path: the first result of a transaction goes from the job register, loaded
//   at accept, to the output register, where it is presented.
// Throughput: 1 input per cycle when each input yields one result and the
//   output is not stalled; an input yielding N results (N = ceil(bytes/2),
//   at least 1, up to 64) holds the job register and the next input until its last result is loaded.
// Reset: rst_n async low; decode state back to control-byte phase, no results
//   pending, row_length returns to 1.
module packbits_row_decoder_core
    import pbrd_pkg::*;
#(
    parameter int unsigned MAX_ROW_BYTES = MAX_ROW_BYTES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    // Compressed input channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,

    // Decoded result channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,

    // row_length register write
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [ROW_LEN_W-1:0] cfg_data
);

    logic [ROW_LEN_W-1:0] row_length_reg;
    logic                 job_busy;
    logic                 in_accept;
    job_t                 job;

    // Register writes are always taken; the user writes only when idle; the block does not check.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_length_reg <= ROW_LENGTH_RESET;
        else if (cfg_valid && cfg_ready)
            row_length_reg <= cfg_data;
    end

    // An input transaction is taken whenever the job register is free or
    // hands off its final result this cycle.
    assign in_stall  = job_busy;
    assign in_accept = in_valid && !job_busy;

    // Decoder: state update happens at the accept edge; the job is built combinationally.
    pbrd_decoder #(
        .MAX_ROW_BYTES(MAX_ROW_BYTES)
    ) u_decoder (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_accept),
        .item       (in_data),
        .row_length (row_length_reg),
        .job        (job)
    );

    // Emitter: slices a job into results behind an output register.
    pbrd_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_load  (in_accept),
        .job       (job),
        .job_busy  (job_busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

FILE: src/pbrd_decoder.sv
// ----------------------------------------------------------------------------
// pbrd_decoder
// PackBits control state; turns one accepted compressed byte into a job.
// ----------------------------------------------------------------------------
module pbrd_decoder
    import pbrd_pkg::*;
#(
    parameter int unsigned MAX_ROW_BYTES = MAX_ROW_BYTES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  in_item_t             item,
    input  logic [ROW_LEN_W-1:0] row_length,
    output job_t                 job
);

    localparam int unsigned LEN_W = $clog2(MAX_ROW_BYTES + 1);
    localparam int unsigned CMP_W = (LEN_W > ROW_LEN_W) ? LEN_W : ROW_LEN_W;
    localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_ROW_BYTES);

    phase_t           phase_reg, phase_next;
    logic [7:0]       pend_reg, pend_next;
    logic [LEN_W-1:0] bw_reg, bw_next;

    logic [CMP_W-1:0] len_full;
    logic [CMP_W-1:0] len_ext;
    logic [CMP_W-1:0] bw_ext;
    logic [CMP_W-1:0] room;
    logic [CMP_W-1:0] bw_sum;
    logic [7:0]       run_len;
    logic [7:0]       nbytes;
    logic [1:0]       status;

    always_comb
    begin
        len_full = CMP_W'(row_length);
        len_ext  = (len_full < MAX_LEN) ? len_full : MAX_LEN;
        bw_ext   = CMP_W'(bw_reg);
        room     = len_ext - bw_ext;
        run_len  = item.in_byte[7] ? 8'(9'd257 - {1'b0, item.in_byte})
                                   : item.in_byte + 8'd1;
        bw_sum   = '0;

        phase_next = phase_reg;
        pend_next  = pend_reg;
        bw_next    = bw_reg;
        nbytes     = 8'd0;
        status     = ROW_CONTINUES;

        if (item.has_byte)
        begin
            case (phase_reg)
                PH_CONTROL:
                begin
                    if (bw_ext >= len_ext)
                    begin
                        phase_next = PH_FAILED;
                    end
                    else if (item.in_byte != CTRL_NOP)
                    begin
                        if (CMP_W'(run_len) > room)
                        begin
                            phase_next = PH_FAILED;
                        end
                        else
                        begin
                            pend_next  = run_len;
                            phase_next = item.in_byte[7] ? PH_REPEAT : PH_LITERAL;
                        end
                    end
                end
                PH_LITERAL:
                begin
                    nbytes    = 8'd1;
                    bw_sum    = bw_ext + CMP_W'(1);
                    bw_next   = bw_sum[LEN_W-1:0];
                    pend_next = pend_reg - 8'd1;
                    if (pend_reg == 8'd1)
                    begin
                        phase_next = PH_CONTROL;
                    end
                end
                PH_REPEAT:
                begin
                    nbytes     = pend_reg;
                    bw_sum     = bw_ext + CMP_W'(pend_reg);
                    bw_next    = bw_sum[LEN_W-1:0];
                    pend_next  = 8'd0;
                    phase_next = PH_CONTROL;
                end
                default:
                begin
                end
            endcase
        end

        // Row verdict uses the state after this byte
        if (item.row_end)
        begin
            if (phase_next == PH_CONTROL && CMP_W'(bw_next) == len_ext)
                status = ROW_OK;
            else
                status = ROW_FAILED;
            phase_next = PH_CONTROL;
            pend_next  = 8'd0;
            bw_next    = '0;
        end

        job.data_byte  = item.in_byte;
        job.byte_total = nbytes;
        job.status     = status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_CONTROL;
            pend_reg  <= 8'd0;
            bw_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
            bw_reg    <= bw_next;
        end
    end

endmodule

FILE: src/pbrd_emitter.sv
// ----------------------------------------------------------------------------
// pbrd_emitter
// Job register and output register; splits a job into results of up to two bytes.
// ----------------------------------------------------------------------------
module pbrd_emitter
    import pbrd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_load,
    input  job_t      job,
    output logic      job_busy,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    logic      job_valid_reg, job_valid_next;
    job_t      job_reg;
    logic [7:0] rem_reg, rem_next;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_reg, out_next;

    logic       out_load;
    logic       final_piece;
    logic [1:0] cnt;

    always_comb
    begin
        out_load    = !out_valid_reg || !out_stall;
        final_piece = (rem_reg <= 8'd2);
        cnt         = (rem_reg >= 8'd2) ? 2'd2 : rem_reg[1:0];

        job_busy = job_valid_reg && !(out_load && final_piece);

        out_next.out_byte_first  = (cnt != 2'd0) ? job_reg.data_byte : 8'd0;
        out_next.out_byte_second = (cnt == 2'd2) ? job_reg.data_byte : 8'd0;
        out_next.byte_count      = cnt;
        out_next.row_status      = final_piece ? job_reg.status : ROW_CONTINUES;
        out_next.last            = final_piece;

        out_valid_next = out_load ? job_valid_reg : out_valid_reg;

        job_valid_next = job_valid_reg;
        rem_next       = rem_reg;
        if (job_load)
        begin
            job_valid_next = 1'b1;
            rem_next       = job.byte_total;
        end
        else if (job_valid_reg && out_load)
        begin
            job_valid_next = !final_piece;
            rem_next       = rem_reg - 8'(cnt);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        if (job_load)
            job_reg <= job;
        if (out_load && job_valid_reg)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

FILE: bench/packbits_row_decoder_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// packbits_row_decoder_core_test
// Self-checking bench for the PackBits row decoder. A clocked driver feeds
// compressed bytes from a queue and runs a cycle-free decoder model on every
// accepted input. A clocked monitor compares every accepted result field by
// field with the oldest predicted one. Both handshakes idle in short random
// bursts, except in the final phase. The row_length register is rewritten
// between phases, only once the decoder has gone idle.
// ----------------------------------------------------------------------------
module packbits_row_decoder_core_test;
    import pbrd_pkg::*;

    // Cycles with no transaction on any channel before the run is abandoned.
    localparam int unsigned STALL_LIMIT = 1000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    in_item_t             in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [ROW_LEN_W-1:0] cfg_data = '0;

    packbits_row_decoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Compressed bytes waiting for the driver, and decoded results still owed.
    in_item_t    pending_inputs[$];
    out_item_t   expected_results[$];
    int unsigned inputs_queued = 0;
    int unsigned inputs_taken = 0;

    // Turned on for the last phase: no idling on either side from then on.
    bit          quiet_tail = 1'b0;
    bit          mismatch_seen = 1'b0;
    int unsigned send_gap = 0;
    int unsigned hold_left = 0;
    int unsigned idle_cycles = 0;

    // ------------------------------------------------------------------------
    // Decoder model: row state and a copy of row_length, advanced once per
    // accepted transaction on the compressed channel.
    // ------------------------------------------------------------------------
    phase_t               dec_phase = PH_CONTROL;
    logic [7:0]           run_left = '0;
    int unsigned          row_fill = 0;
    logic [ROW_LEN_W-1:0] row_len_cfg = ROW_LENGTH_RESET;

    function automatic void decode_input(in_item_t it);
        int unsigned len;
        int unsigned byte_val;
        int unsigned produced;
        int unsigned n_res;
        int unsigned run;
        logic [1:0]  verdict;
        out_item_t   r;
        len      = (row_len_cfg < MAX_ROW_BYTES_DEF) ? row_len_cfg : MAX_ROW_BYTES_DEF;
        byte_val = it.in_byte;
        produced = 0;
        verdict  = ROW_CONTINUES;
        if (it.has_byte)
        begin
            case (dec_phase)
                PH_CONTROL:
                begin
                    // Any byte once the row is full is an overrun, the skip
                    // code included.
                    if (row_fill >= len)
                        dec_phase = PH_FAILED;
                    else if (byte_val < 128)
                    begin
                        if (byte_val + 1 > len - row_fill)
                            dec_phase = PH_FAILED;
                        else
                        begin
                            run_left  = 8'(byte_val + 1);
                            dec_phase = PH_LITERAL;
                        end
                    end
                    else if (it.in_byte != CTRL_NOP)
                    begin
                        run = 257 - byte_val;
                        if (run > len - row_fill)
                            dec_phase = PH_FAILED;
                        else
                        begin
                            run_left  = 8'(run);
                            dec_phase = PH_REPEAT;
                        end
                    end
                end
                PH_LITERAL:
                begin
                    produced = 1;
                    row_fill += 1;
                    run_left -= 8'd1;
                    if (run_left == 0)
                        dec_phase = PH_CONTROL;
                end
                PH_REPEAT:
                begin
                    produced = run_left;
                    row_fill += produced;
                    run_left = '0;
                    dec_phase = PH_CONTROL;
                end
                default:
                    ; // failed row: bytes are dropped until row end
            endcase
        end

        // The byte on a row-end transaction is decoded first, then judged.
        if (it.row_end)
        begin
            verdict   = (dec_phase == PH_CONTROL && row_fill == len) ? ROW_OK : ROW_FAILED;
            dec_phase = PH_CONTROL;
            run_left  = '0;
            row_fill  = 0;
        end

        // Up to two bytes per result; a transaction with nothing decoded still
        // gives one empty result.
        n_res = (produced + 1) / 2;
        if (n_res == 0)
            n_res = 1;
        for (int unsigned k = 0; k < n_res; k++)
        begin
            r.out_byte_first  = (2 * k < produced) ? it.in_byte : 8'd0;
            r.out_byte_second = (2 * k + 1 < produced) ? it.in_byte : 8'd0;
            r.byte_count      = (2 * k + 1 < produced) ? 2'd2 : (2 * k < produced) ? 2'd1 : 2'd0;
            r.row_status      = (k + 1 == n_res) ? verdict : ROW_CONTINUES;
            r.last            = (k + 1 == n_res);
            expected_results.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driver: runs the model on each accepted transaction, then presents the
    // next queued item unless a random gap is under way. A stalled item is
    // held unchanged.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        bit took;
        bit next_valid;
        if (rst_n)
        begin
            took = in_valid && !in_stall;
            if (took)
            begin
                decode_input(in_data);
                inputs_taken++;
            end
            if (!in_valid || took)
            begin
                next_valid = 1'b0;
                if (send_gap > 0)
                    send_gap--;
                else if (pending_inputs.size() > 0)
                begin
                    in_data <= pending_inputs.pop_front();
                    next_valid = 1'b1;
                    if (!quiet_tail && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 3);
                end
                in_valid <= next_valid;
            end
        end
    end

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_seen = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: checks accepted results in order, drives random stall bursts
    // on the result side and keeps the no-progress watchdog.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_item_t want;
        bit        took_out;
        if (rst_n)
        begin
            took_out = out_valid && !out_stall;
            if (took_out)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with nothing predicted: %p", out_data);
                    mismatch_seen = 1'b1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("out_byte_first", want.out_byte_first, out_data.out_byte_first);
                    check_field("out_byte_second", want.out_byte_second,
                                out_data.out_byte_second);
                    check_field("byte_count", want.byte_count, out_data.byte_count);
                    check_field("row_status", want.row_status, out_data.row_status);
                    check_field("last", want.last, out_data.last);
                end
            end

            // random stall bursts
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                hold_left = $urandom_range(0, 2);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;

            if (took_out || (in_valid && !in_stall) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("packbits_row_decoder_core: mismatch");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic in_item_t mk_item(bit has, logic [7:0] b, bit row_end);
        in_item_t it;
        it.has_byte = has;
        it.in_byte  = b;
        it.row_end  = row_end;
        return it;
    endfunction

    function automatic void queue_input(bit has, logic [7:0] b, bit row_end);
        pending_inputs.push_back(mk_item(has, b, row_end));
        inputs_queued++;
    endfunction

    // One compressed row aimed at len decoded bytes. Most rows are well formed
    // with random content; the rest carry a trailing byte, lose their last
    // byte, or are plain noise.
    task automatic queue_row(int unsigned len);
        in_item_t    row_items[$];
        int unsigned flavor;
        int unsigned left;
        int unsigned n;
        int unsigned pick;
        flavor = $urandom_range(0, 9);
        if (flavor == 9)
        begin
            n = $urandom_range(1, 6);
            for (int unsigned k = 0; k < n; k++)
                queue_input(1'($urandom_range(0, 1)), 8'($urandom), k + 1 == n);
            return;
        end
        left = len;
        while (left > 0)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                row_items.push_back(mk_item(1'b1, CTRL_NOP, 1'b0));
            else if (pick < 5 || left == 1)
            begin
                // literal of one to six bytes, never more than is left
                n = $urandom_range(1, (left < 6) ? left : 6);
                row_items.push_back(mk_item(1'b1, 8'(n - 1), 1'b0));
                for (int unsigned k = 0; k < n; k++)
                begin
                    row_items.push_back(mk_item(1'b1, 8'($urandom), 1'b0));
                    if ($urandom_range(0, 11) == 0)
                        row_items.push_back(mk_item(1'b0, 8'($urandom), 1'b0));
                end
                left -= n;
            end
            else
            begin
                n = $urandom_range(2, (left < 128) ? left : 128);
                row_items.push_back(mk_item(1'b1, 8'(257 - n), 1'b0));
                row_items.push_back(mk_item(1'b1, 8'($urandom), 1'b0));
                left -= n;
            end
        end
        if (flavor == 8 && row_items.size() > 0)
            void'(row_items.pop_back());
        else if (flavor == 7)
            row_items.push_back(mk_item(1'b1, 8'($urandom), 1'b0));
        // end on the last byte, or on a separate empty marker
        if (row_items.size() > 0 && $urandom_range(0, 1) == 1)
            row_items[row_items.size() - 1].row_end = 1'b1;
        else
            row_items.push_back(mk_item(1'b0, 8'($urandom), 1'b1));
        foreach (row_items[k])
        begin
            pending_inputs.push_back(row_items[k]);
            inputs_queued++;
        end
    endtask

    // Every input here yields at least one result, so once nothing is owed the
    // decoder is idle; spare cycles after that cover the pipeline.
    task automatic wait_idle();
        while (inputs_taken != inputs_queued || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_row_length(logic [ROW_LEN_W-1:0] value);
        @(posedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        row_len_cfg = value;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned phase_start;
        int unsigned len;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows at the reset row_length of 1.
        queue_input(1'b1, 8'h00, 1'b0);          // one-byte literal, ends on its byte
        queue_input(1'b1, 8'hAA, 1'b1);
        queue_input(1'b0, 8'hFF, 1'b1);          // empty row: too short
        queue_input(1'b1, 8'hFF, 1'b0);          // repeat of 2 overruns
        queue_input(1'b1, 8'h55, 1'b1);          // discarded, row fails
        queue_input(1'b1, CTRL_NOP, 1'b0);       // skip code, then a literal
        queue_input(1'b1, 8'h00, 1'b0);
        queue_input(1'b1, 8'h5A, 1'b0);
        queue_input(1'b0, 8'h00, 1'b1);          // separate end marker
        queue_input(1'b1, 8'h00, 1'b0);
        queue_input(1'b1, 8'h11, 1'b0);
        queue_input(1'b1, CTRL_NOP, 1'b1);       // skip code after the row is full
        wait_idle();

        // Zero-length rows: empty succeeds, any byte fails.
        write_row_length('0);
        queue_input(1'b0, 8'h00, 1'b1);
        queue_input(1'b1, CTRL_NOP, 1'b1);
        wait_idle();

        // Longest row: full 128-byte run, a 128-byte literal cut short, and a
        // row ending while its repeat byte is still due.
        write_row_length(15'h7FFF);
        queue_input(1'b1, 8'h81, 1'b0);
        queue_input(1'b1, 8'hFF, 1'b0);
        queue_input(1'b1, 8'h7F, 1'b0);
        queue_input(1'b1, 8'h01, 1'b0);
        queue_input(1'b1, 8'hFE, 1'b1);
        queue_input(1'b1, 8'h82, 1'b1);
        wait_idle();

        // Random rows over several row lengths, the last phase without idling.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       len = $urandom_range(2, 9);
                1:       len = $urandom_range(10, 40);
                2:       len = $urandom_range(100, 400);
                default: len = $urandom_range(1, 24);
            endcase
            write_row_length(ROW_LEN_W'(len));
            quiet_tail = (ph == 3);
            phase_start = inputs_queued;
            while (inputs_queued - phase_start < 20)
                queue_row(len);
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d predicted results never arrived", expected_results.size());
            mismatch_seen = 1'b1;
        end
        if (!mismatch_seen)
            $display("packbits_row_decoder_core: match");
        else
            $display("packbits_row_decoder_core: mismatch");
        $finish;
    end

endmodule
